>>> rtl/slnt_pkg.sv
// Package for the sorted leaf node table: widths, command and status codes,
// the cell control bundle and the result record.
// No dependencies; used by slnt_cell and sorted_leaf_node_table_top.
package slnt_pkg;

   localparam int CAPACITY = 64;            // entries held in the cell chain
   localparam int KEY_W    = 32;
   localparam int REC_W    = 32;
   localparam int IDX_W    = 6;             // index of one cell
   localparam int CNT_W    = 7;             // count and position, 0 to CAPACITY
   localparam int CMD_W    = 2;
   localparam int STS_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOCATE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_NOT_FOUND = 2'd2,
      STS_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic             load_flag;   // capture the compare result
      logic             commit;      // apply shift / write of an insert
      logic [KEY_W-1:0] key;         // key being inserted or searched
      logic [REC_W-1:0] rec;         // record id being inserted
   } cell_ctrl_type;

   typedef struct packed {
      logic [STS_W-1:0] status;
      logic [CNT_W-1:0] position;
      logic [KEY_W-1:0] entry_key;
      logic [REC_W-1:0] entry_record;
      logic [CNT_W-1:0] entry_count;
   } rsp_type;

endpackage

>>> rtl/slnt_cell.sv
// One cell of the sorted table: holds a key, a record id and a compare flag.
// Depends on slnt_pkg.
module slnt_cell (
   input  logic                         clock,
   input  slnt_pkg::cell_ctrl_type      ctrl,
   input  logic                         live,       // cell index below count
   input  logic                         sel,        // cell addressed by a read
   input  logic [slnt_pkg::KEY_W-1:0]   prev_key,
   input  logic [slnt_pkg::REC_W-1:0]   prev_rec,
   input  logic                         prev_flag,
   output logic [slnt_pkg::KEY_W-1:0]   key_out,
   output logic [slnt_pkg::REC_W-1:0]   rec_out,
   output logic                         flag_out,
   output logic                         first_out,
   output logic [slnt_pkg::KEY_W-1:0]   rd_key,
   output logic [slnt_pkg::REC_W-1:0]   rd_rec
);

   logic [slnt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [slnt_pkg::REC_W-1:0] rec_ff, rec_in;
   logic                       flag_ff, flag_in;

   // Flag: stored key at least the search key, or cell at or above the count.
   assign flag_in = !live || ($signed(key_ff) >= $signed(ctrl.key));

   // Shift up from the neighbour below the insert point, write at it, hold otherwise.
   always_comb begin
      if (prev_flag) begin
         key_in = prev_key;
         rec_in = prev_rec;
      end else if (flag_ff) begin
         key_in = ctrl.key;
         rec_in = ctrl.rec;
      end else begin
         key_in = key_ff;
         rec_in = rec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_flag) begin
         flag_ff <= flag_in;
      end
      if (ctrl.commit) begin
         key_ff <= key_in;
         rec_ff <= rec_in;
      end
   end

   assign key_out   = key_ff;
   assign rec_out   = rec_ff;
   assign flag_out  = flag_ff;
   assign first_out = flag_ff && !prev_flag;
   assign rd_key    = sel ? key_ff : '0;
   assign rd_rec    = sel ? rec_ff : '0;

endmodule

>>> rtl/sorted_leaf_node_table_top.sv
// Top level of the sorted leaf node table: handshake, sequencer, chain of cells
// and result register. Depends on slnt_pkg and slnt_cell.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  req     | in        | search_key, record_id, entry_index          | command
//  rsp     | out       | position, entry_key, entry_record, entry_cnt | status
//
// Items run one at a time: in the accept cycle every cell compares its key
// with the search key and registers the flag; in the next cycle the flags are
// encoded into the lower-bound position and an insert shifts and writes the
// chain in one step. The compare-then-shift of the cell chain sets the rate.
// Reset clears the count, the sequencer and the output valid only; the stores
// need no clearing pass, since entries at or above the count are never read.
// A result waits in an output register; an idle sequencer takes the next item
// as soon as that register is empty or is being drained in the same cycle.
module sorted_leaf_node_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // search_key[31:0], record_id[63:32],
                                    // entry_index[69:64], zero pad[71:70]
   input  logic [1:0]  req_tuser,   // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // position[6:0], entry_key[38:7],
                                    // entry_record[70:39], entry_count[77:71],
                                    // zero pad[79:78]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int CAP = slnt_pkg::CAPACITY;

   slnt_pkg::fsm_type state_ff, state_in;

   // Latched request
   logic [slnt_pkg::CMD_W-1:0] cmd_ff;
   logic [slnt_pkg::KEY_W-1:0] key_ff;
   logic [slnt_pkg::REC_W-1:0] rec_ff;
   logic [slnt_pkg::IDX_W-1:0] idx_ff;

   logic [slnt_pkg::CNT_W-1:0] count_ff, count_in;
   slnt_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic req_xfer, exec, full, commit;
   slnt_pkg::cell_ctrl_type ctrl;

   // Chain wiring
   logic [slnt_pkg::KEY_W-1:0] cell_key [CAP];
   logic [slnt_pkg::REC_W-1:0] cell_rec [CAP];
   logic [slnt_pkg::KEY_W-1:0] cell_rd_key [CAP];
   logic [slnt_pkg::REC_W-1:0] cell_rd_rec [CAP];
   logic [CAP-1:0]             flag_vec, first_vec, live_vec, sel_vec;

   logic [slnt_pkg::IDX_W-1:0] pos_low;
   logic [slnt_pkg::CNT_W-1:0] position;
   logic [slnt_pkg::KEY_W-1:0] rd_key;
   logic [slnt_pkg::REC_W-1:0] rd_rec;

   assign req_xfer = req_tvalid && req_tready;
   assign exec     = (state_ff == slnt_pkg::FSM_EXEC);
   assign full     = (count_ff >= slnt_pkg::CNT_W'(CAP));
   assign commit   = exec && (cmd_ff == slnt_pkg::CMD_INSERT) && !full;

   // Broadcast: search key straight from the port in the accept cycle,
   // from the latched request while committing.
   always_comb begin
      ctrl.load_flag = req_xfer;
      ctrl.commit    = commit;
      ctrl.key       = exec ? key_ff : req_tdata[31:0];
      ctrl.rec       = rec_ff;
   end

   // Cell chain: each cell hands its key, record and flag to the next one up.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      logic [slnt_pkg::KEY_W-1:0] prev_key;
      logic [slnt_pkg::REC_W-1:0] prev_rec;
      logic                       prev_flag;

      if (i == 0) begin : g_head
         assign prev_key  = '0;
         assign prev_rec  = '0;
         assign prev_flag = 1'b0;
      end else begin : g_link
         assign prev_key  = cell_key[i-1];
         assign prev_rec  = cell_rec[i-1];
         assign prev_flag = flag_vec[i-1];
      end

      assign live_vec[i] = (slnt_pkg::CNT_W'(i) < count_ff);
      assign sel_vec[i]  = (idx_ff == slnt_pkg::IDX_W'(i));

      slnt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .live      (live_vec[i]),
         .sel       (sel_vec[i]),
         .prev_key  (prev_key),
         .prev_rec  (prev_rec),
         .prev_flag (prev_flag),
         .key_out   (cell_key[i]),
         .rec_out   (cell_rec[i]),
         .flag_out  (flag_vec[i]),
         .first_out (first_vec[i]),
         .rd_key    (cell_rd_key[i]),
         .rd_rec    (cell_rd_rec[i])
      );
   end

   // Flags form a thermometer code, so at most one cell marks the boundary:
   // OR its index together; no boundary at all means the position is CAPACITY.
   always_comb begin
      pos_low = '0;
      rd_key  = '0;
      rd_rec  = '0;
      for (int i = 0; i < CAP; i++) begin
         if (first_vec[i]) begin
            pos_low = pos_low | slnt_pkg::IDX_W'(i);
         end
         rd_key = rd_key | cell_rd_key[i];
         rd_rec = rd_rec | cell_rd_rec[i];
      end
   end
   assign position = {!flag_vec[CAP-1], pos_low};

   // Sequencer: take an item, then execute it in the following cycle.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         slnt_pkg::FSM_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            if (req_xfer) begin
               state_in = slnt_pkg::FSM_EXEC;
            end
         end
         slnt_pkg::FSM_EXEC: begin
            state_in = slnt_pkg::FSM_IDLE;
         end
         default: begin
            state_in = slnt_pkg::FSM_IDLE;
         end
      endcase
   end

   // Build the result of the latched item.
   always_comb begin
      count_in            = count_ff;
      rsp_in.status       = slnt_pkg::STS_OK;
      rsp_in.position     = '0;
      rsp_in.entry_key    = '0;
      rsp_in.entry_record = '0;
      unique case (cmd_ff)
         slnt_pkg::CMD_INSERT: begin
            if (full) begin
               rsp_in.status = slnt_pkg::STS_FULL;
            end else begin
               rsp_in.position = position;
               count_in        = count_ff + slnt_pkg::CNT_W'(1);
            end
         end
         slnt_pkg::CMD_LOCATE: begin
            rsp_in.position = position;
            if (position >= count_ff) begin
               rsp_in.status = slnt_pkg::STS_NOT_FOUND;
            end
         end
         slnt_pkg::CMD_READ: begin
            if ({1'b0, idx_ff} < count_ff) begin
               rsp_in.entry_key    = rd_key;
               rsp_in.entry_record = rd_rec;
            end else begin
               rsp_in.status = slnt_pkg::STS_RANGE;
            end
         end
         default: begin
            rsp_in.status = slnt_pkg::STS_RANGE;
         end
      endcase
      rsp_in.entry_count = count_in;
   end

   // Load the result register on execute, drop it once transferred.
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slnt_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // Payload registers: hold the request and the result.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff <= req_tuser;
         key_ff <= req_tdata[31:0];
         rec_ff <= req_tdata[63:32];
         idx_ff <= req_tdata[69:64];
      end
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {2'b00, rsp_ff.entry_count, rsp_ff.entry_record,
                        rsp_ff.entry_key, rsp_ff.position};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= slnt_pkg::CNT_W'(CAP))
      else $error("entry count beyond capacity");

   a_single_boundary: assert property (@(posedge clock) disable iff (reset)
      exec |-> $onehot0(first_vec))
      else $error("cell flags are not a thermometer code");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(exec))
      else $error("result raised without an executed item");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      commit |=> count_ff == $past(count_ff) + slnt_pkg::CNT_W'(1))
      else $error("insert did not advance the count");

endmodule

>>> test/slnt_result_monitor.sv
// Result monitor for the sorted leaf node table: watches both stream channels,
// keeps its own sorted copy of the table and compares every result with it.
// Depends on slnt_pkg for widths and codes; instantiated by tb_top.
module slnt_result_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          outstanding,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W = slnt_pkg::KEY_W;
   localparam int REC_W = slnt_pkg::REC_W;
   localparam int CNT_W = slnt_pkg::CNT_W;
   localparam int IDX_W = slnt_pkg::IDX_W;

   logic signed [KEY_W-1:0] key_tab [slnt_pkg::CAPACITY];
   logic        [REC_W-1:0] rec_tab [slnt_pkg::CAPACITY];
   int                      held = 0;
   slnt_pkg::rsp_type       awaited_results [$];
   int                      mismatches = 0;

   assign fail_count = mismatches;

   // first entry whose key is not below k, or the count when none is
   function automatic int lower_bound_of(logic signed [KEY_W-1:0] k);
      for (int i = 0; i < held; i++)
         if (key_tab[i] >= k) return i;
      return held;
   endfunction

   function automatic slnt_pkg::rsp_type apply_leaf_command(
         logic [slnt_pkg::CMD_W-1:0] cmd,
         logic signed [KEY_W-1:0]    key,
         logic [REC_W-1:0]           rec,
         logic [IDX_W-1:0]           idx);
      slnt_pkg::rsp_type r;
      int                pos;
      r = '0;
      r.status = slnt_pkg::STS_OK;
      case (cmd)
         slnt_pkg::CMD_INSERT: begin
            if (held >= slnt_pkg::CAPACITY) begin
               r.status = slnt_pkg::STS_FULL;
            end else begin
               pos = lower_bound_of(key);
               for (int i = held; i > pos; i--) begin
                  key_tab[i] = key_tab[i-1];
                  rec_tab[i] = rec_tab[i-1];
               end
               key_tab[pos] = key;
               rec_tab[pos] = rec;
               held++;
               r.position = CNT_W'(pos);
            end
         end
         slnt_pkg::CMD_LOCATE: begin
            pos = lower_bound_of(key);
            r.position = CNT_W'(pos);
            if (pos >= held) r.status = slnt_pkg::STS_NOT_FOUND;
         end
         slnt_pkg::CMD_READ: begin
            if (idx < held) begin
               r.entry_key    = key_tab[idx];
               r.entry_record = rec_tab[idx];
            end else begin
               r.status = slnt_pkg::STS_RANGE;
            end
         end
         default: r.status = slnt_pkg::STS_RANGE;
      endcase
      r.entry_count = CNT_W'(held);
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      slnt_pkg::rsp_type want;
      slnt_pkg::rsp_type got;
      if (!reset) begin
         // results first, so a transfer pairs only with older requests
         if (rsp_tvalid && rsp_tready) begin
            got.status       = rsp_tuser;
            got.position     = rsp_tdata[0 +: CNT_W];
            got.entry_key    = rsp_tdata[CNT_W +: KEY_W];
            got.entry_record = rsp_tdata[CNT_W+KEY_W +: REC_W];
            got.entry_count  = rsp_tdata[CNT_W+KEY_W+REC_W +: CNT_W];
            if (awaited_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got %0h",
                        $time, got);
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, got.status);
               check_field("position", want.position, got.position);
               check_field("entry_key", want.entry_key, got.entry_key);
               check_field("entry_record", want.entry_record, got.entry_record);
               check_field("entry_count", want.entry_count, got.entry_count);
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(apply_leaf_command(req_tuser,
                                         req_tdata[0 +: KEY_W],
                                         req_tdata[KEY_W +: REC_W],
                                         req_tdata[KEY_W+REC_W +: IDX_W]));
      end
      outstanding <= awaited_results.size();
   end

endmodule

>>> test/tb_top.sv
// Top of the sorted leaf node table testbench: clock, reset, stimulus and
// verdict. Depends on slnt_pkg, sorted_leaf_node_table_top and slnt_result_monitor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CMD_W = slnt_pkg::CMD_W;
   localparam int KEY_W = slnt_pkg::KEY_W;
   localparam int REC_W = slnt_pkg::REC_W;
   localparam int IDX_W = slnt_pkg::IDX_W;

   localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;   // decodes to nothing
   localparam logic [KEY_W-1:0] KEY_MIN      = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX      = 32'h7FFF_FFFF;
   localparam int               RANDOM_ITEMS = 1900;
   localparam int               CALM_ITEMS   = 200;    // tail with no idling
   localparam int               STALL_LIMIT  = 1000;   // cycles without a transfer

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int          outstanding;
   int          fail_count;
   int          quiet_cycles = 0;
   int          inserts_sent = 0;
   bit          calm = 1'b0;
   logic [KEY_W-1:0] sent_keys [$];   // keys inserted so far, for near hits

   sorted_leaf_node_table_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   slnt_result_monitor u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Present one request and hold it until the transfer takes place.
   // tdata: search_key, record_id, entry_index, zero pad; tuser: command.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [REC_W-1:0] rec, input logic [IDX_W-1:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, idx, rec, key};
      do @(posedge clock); while (!req_tready);
      if (cmd == slnt_pkg::CMD_INSERT) begin
         inserts_sent++;
         sent_keys.push_back(key);
      end
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending and wait for every predicted result to come back.
   // The monitor updates its count with a nonblocking write, so the value read
   // here at an edge always reflects the transfers up to the previous edge.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Keys: wide random values, a narrow band round zero for duplicates, the
   // signed extremes, and neighbours of keys already held.
   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5:       return $urandom_range(0, 16) - 8;
         6: begin
            case ($urandom_range(0, 3))
               0:       return KEY_MIN;
               1:       return KEY_MAX;
               2:       return KEY_MIN + 1;
               default: return KEY_MAX - 1;
            endcase
         end
         default: begin
            if (sent_keys.size() == 0) return $urandom;
            return sent_keys[$urandom_range(0, sent_keys.size() - 1)]
                   + $urandom_range(0, 2) - 1;
         end
      endcase
   endfunction

   // Result side: drop tready for bursts of random length, none in the tail.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int               roll;
      int               filled;
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, then a small table built round the extremes.
      send_item(slnt_pkg::CMD_READ, '0, '0, '0);    // nothing held: out of range
      send_item(slnt_pkg::CMD_LOCATE, '0, '0, '0);  // nothing held: not found at 0
      send_item(CMD_UNUSED, $urandom, $urandom, IDX_W'($urandom_range(0, 63)));
      send_item(slnt_pkg::CMD_INSERT, '0, 32'h0000_0001, '0);
      send_item(slnt_pkg::CMD_LOCATE, 32'd5, '0, '0);    // above every key held
      send_item(slnt_pkg::CMD_INSERT, 32'd5, 32'hFFFF_FFFF, 6'h3F);  // appends at the count
      send_item(slnt_pkg::CMD_INSERT, KEY_MIN, 32'h0000_0000, '0);
      send_item(slnt_pkg::CMD_INSERT, KEY_MAX, 32'hA5A5_5A5A, '0);
      send_item(slnt_pkg::CMD_INSERT, '0, 32'h0000_0002, '0); // equal key lands first
      send_item(slnt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5, '0);
      send_item(slnt_pkg::CMD_LOCATE, KEY_MIN, '0, '0);
      send_item(slnt_pkg::CMD_LOCATE, KEY_MAX, '0, '0);
      send_item(slnt_pkg::CMD_LOCATE, '0, '0, '0);
      send_item(slnt_pkg::CMD_LOCATE, 32'd1, '0, '0);
      for (int i = 0; i <= 6; i++)
         send_item(slnt_pkg::CMD_READ, '0, '0, IDX_W'(i));  // last one sits at the count
      send_item(slnt_pkg::CMD_READ, '0, '0, 6'h3F);

      // hold the sender until the table is quiet
      drain_results();

      // Random: inserts are rare so the table fills slowly, and are forced late
      // on so that it is full, and refuses a few more, well before the end.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         if (n == RANDOM_ITEMS / 2)
            drain_results();
         roll = $urandom_range(0, 99);
         if (roll < 6 ||
             (n >= RANDOM_ITEMS * 5 / 8 && inserts_sent < slnt_pkg::CAPACITY + 6))
            cmd = slnt_pkg::CMD_INSERT;
         else if (roll < 50)
            cmd = slnt_pkg::CMD_LOCATE;
         else if (roll < 95)
            cmd = slnt_pkg::CMD_READ;
         else
            cmd = CMD_UNUSED;
         filled = (inserts_sent < slnt_pkg::CAPACITY) ? inserts_sent : slnt_pkg::CAPACITY;
         if ($urandom_range(0, 1) == 1 && filled > 0)
            idx = IDX_W'($urandom_range(0, filled - 1));
         else
            idx = IDX_W'($urandom_range(0, 63));
         send_item(cmd, pick_key(), $urandom, idx);
         // every third stretch of 150 items runs without sender gaps
         if (!calm && (n / 150) % 3 != 2 && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
      end

      drain_results();
      repeat (8) @(posedge clock);   // catch any stray late result

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
